@@ sv/scba_pkg.sv @@
// shared types and constants for the size class buffer allocator
`default_nettype none
package scba_pkg;

  localparam int HANDLE_SLOTS = 64;
  localparam int STACK_DEPTH  = 256;
  localparam int CLASS_COUNT  = 4;

  localparam int SLOT_W  = $clog2(HANDLE_SLOTS);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW  = $clog2(CLASS_COUNT * STACK_DEPTH);
  localparam int CLS_W   = $clog2(CLASS_COUNT + 1);

  localparam logic [31:0] KIB4       = 32'(4 * 1024);
  localparam logic [31:0] KIB512     = 32'(512 * 1024);
  localparam logic [31:0] MIB4       = 32'(4 * 1024 * 1024);
  localparam logic [31:0] MIB12      = 32'(12 * 1024 * 1024);
  localparam logic [31:0] PAGE_MASK  = 32'd4095;
  localparam logic [31:0] POOL_RESET = 32'(1024 * 1024 * 1024);
  localparam logic [32:0] PTR_MAX    = {33{1'b1}};
  localparam logic [15:0] REFS_MAX   = 16'hFFFF;
  localparam logic [CLS_W-1:0] CLS_NONE = CLS_W'(CLASS_COUNT);

  localparam logic [2:0] ADDR_POOL_SIZE = 3'd0;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RETAIN  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNKNOWN   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SEL,
    S_EXEC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic select;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic [30:0] offset;
    logic [30:0] bytes;
    logic [15:0] refs;
  } tent_t;

endpackage
`default_nettype wire

@@ sv/scba_if.sv @@
// request and response channel interfaces
`default_nettype none
interface scba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [30:0] req_size;
  logic [31:0] handle_in;
  modport source (output valid, cmd, req_size, handle_in, input ready);
  modport sink   (input valid, cmd, req_size, handle_in, output ready);
endinterface

interface scba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] handle_out;
  logic [30:0] block_offset;
  logic [30:0] block_bytes;
  logic        freed;
  modport source (output valid, status, handle_out, block_offset, block_bytes, freed,
                  input ready);
  modport sink   (input valid, status, handle_out, block_offset, block_bytes, freed,
                  output ready);
endinterface
`default_nettype wire

@@ sv/scba_ctrl.sv @@
// sequencing state machine for the allocator
`default_nettype none
module scba_ctrl
  import scba_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        ctrl_o.lookup = 1'b1;
        state_d = S_SEL;
      end
      S_SEL: begin
        ctrl_o.select = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/scba_dp.sv @@
// handle table, class stacks, bump pointer and result register
`default_nettype none
module scba_dp
  import scba_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_t       ctrl_i,
  input  wire logic [31:0] pool_size_i,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [30:0] req_size_i,
  input  wire logic [31:0] handle_in_i,
  output logic [1:0]       status_o,
  output logic [31:0]      handle_out_o,
  output logic [30:0]      block_offset_o,
  output logic [30:0]      block_bytes_o,
  output logic             freed_o
);

  function automatic logic [31:0] round_size(input logic [30:0] s);
    logic [31:0] w;
    w = {1'b0, s};
    if (w <= KIB4)        return KIB4;
    else if (w <= KIB512) return KIB512;
    else if (w <= MIB4)   return MIB4;
    else if (w <= MIB12)  return MIB12;
    else                  return (w + PAGE_MASK) & ~PAGE_MASK;
  endfunction

  function automatic logic [CLS_W-1:0] class_of(input logic [31:0] s);
    if (s == KIB4)        return CLS_W'(0);
    else if (s == KIB512) return CLS_W'(1);
    else if (s == MIB4)   return CLS_W'(2);
    else if (s == MIB12)  return CLS_W'(3);
    else                  return CLS_NONE;
  endfunction

  function automatic logic [SLOT_W-1:0] first_set(input logic [HANDLE_SLOTS-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = HANDLE_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = SLOT_W'(i);
    end
    return r;
  endfunction

  // persistent state
  logic [32:0]             bump_q;
  logic [31:0]             next_handle_q;
  logic [HANDLE_SLOTS-1:0] valid_q;
  logic [31:0]             hdl_q [HANDLE_SLOTS];
  tent_t                   tmem [HANDLE_SLOTS];
  logic [30:0]             stk_mem [CLASS_COUNT * STACK_DEPTH];
  logic [CNT_W-1:0]        cnt_q [CLASS_COUNT];

  // per item registers
  logic [1:0]              cmd_q;
  logic [31:0]             size_q;
  logic [CLS_W-1:0]        cls_q;
  logic [31:0]             hin_q;
  logic [31:0]             key_q;
  logic [HANDLE_SLOTS-1:0] match_q, free_q;
  logic                    hit_q;
  logic [SLOT_W-1:0]       slot_q;
  tent_t                   trd_q;
  logic [30:0]             srd_q;

  logic                    found;
  logic [SLOT_W-1:0]       slot_d;
  logic [STK_AW-1:0]       pop_addr;
  logic [1:0]              cls_lo;

  assign cls_lo = cls_q[1:0];
  assign found  = |match_q;
  assign slot_d = found ? first_set(match_q) : first_set(free_q);
  assign pop_addr = STK_AW'(cls_lo * STACK_DEPTH) + STK_AW'(cnt_q[cls_lo] - 1'b1);

  // exec stage
  logic [33:0]       sum;
  logic [32:0]       nxt;
  logic              pop_ok;
  tent_t             ent_d;
  logic [15:0]       refs_dec;
  logic [CLS_W-1:0]  fcls;
  logic [1:0]        fcls_lo;
  logic [STK_AW-1:0] push_addr;

  assign sum     = {1'b0, bump_q} + 34'(size_q);
  assign nxt     = (sum > 34'(PTR_MAX)) ? PTR_MAX : sum[32:0];
  assign pop_ok  = (cls_q != CLS_NONE) && (cnt_q[cls_lo] != '0);
  assign refs_dec = (trd_q.refs != '0) ? trd_q.refs - 16'd1 : 16'd0;
  assign fcls    = class_of({1'b0, trd_q.bytes});
  assign fcls_lo = fcls[1:0];
  assign push_addr = STK_AW'(fcls_lo * STACK_DEPTH) + STK_AW'(cnt_q[fcls_lo]);

  // table entry as written back by the exec stage
  always_comb begin
    ent_d = trd_q;
    case (cmd_q)
      CMD_ALLOC: begin
        ent_d.offset = pop_ok ? srd_q : bump_q[30:0];
        ent_d.bytes  = size_q[30:0];
        ent_d.refs   = 16'd1;
      end
      CMD_RETAIN: begin
        ent_d.refs = (trd_q.refs != REFS_MAX) ? trd_q.refs + 16'd1 : REFS_MAX;
      end
      CMD_RELEASE: begin
        ent_d.refs = refs_dec;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= cmd_i;
      size_q <= round_size(req_size_i);
      cls_q  <= class_of(round_size(req_size_i));
      hin_q  <= handle_in_i;
      key_q  <= (cmd_i == CMD_ALLOC) ? next_handle_q : handle_in_i;
    end
    if (ctrl_i.lookup) begin
      for (int i = 0; i < HANDLE_SLOTS; i++) begin
        match_q[i] <= valid_q[i] && (hdl_q[i] == key_q);
        free_q[i]  <= !valid_q[i];
      end
    end
    if (ctrl_i.select) begin
      slot_q <= slot_d;
      hit_q  <= (cmd_q == CMD_ALLOC) ? (found || (|free_q)) : found;
      trd_q  <= tmem[slot_d];
      srd_q  <= stk_mem[pop_addr];
    end
    if (ctrl_i.exec) begin
      case (cmd_q)
        CMD_ALLOC: begin
          if (hit_q && (pop_ok || nxt < {1'b0, pool_size_i})) begin
            tmem[slot_q]  <= ent_d;
            hdl_q[slot_q] <= key_q;
          end
        end
        CMD_RELEASE, CMD_RETAIN: begin
          if (hit_q) begin
            tmem[slot_q] <= ent_d;
            if (cmd_q == CMD_RELEASE && refs_dec == '0 && fcls != CLS_NONE &&
                cnt_q[fcls_lo] < CNT_W'(STACK_DEPTH)) begin
              stk_mem[push_addr] <= trd_q.offset;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      status_o       <= ST_OK;
      handle_out_o   <= hin_q;
      block_offset_o <= '0;
      block_bytes_o  <= '0;
      freed_o        <= 1'b0;
      case (cmd_q)
        CMD_ALLOC: begin
          handle_out_o <= '0;
          if (!hit_q) begin
            status_o <= ST_FULL;
          end else if (pop_ok || nxt < {1'b0, pool_size_i}) begin
            handle_out_o   <= key_q;
            block_offset_o <= pop_ok ? srd_q : bump_q[30:0];
            block_bytes_o  <= size_q[30:0];
          end else begin
            status_o <= ST_EXHAUSTED;
          end
        end
        CMD_RELEASE, CMD_RETAIN: begin
          if (!hit_q) begin
            status_o <= ST_UNKNOWN;
          end else begin
            block_offset_o <= trd_q.offset;
            block_bytes_o  <= trd_q.bytes;
            freed_o        <= (cmd_q == CMD_RELEASE) && (refs_dec == '0);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q        <= '0;
      next_handle_q <= '0;
      valid_q       <= '0;
      for (int c = 0; c < CLASS_COUNT; c++) cnt_q[c] <= '0;
    end else begin
      if (ctrl_i.capture && cmd_i == CMD_ALLOC) begin
        next_handle_q <= next_handle_q + 32'd1;
      end
      if (ctrl_i.exec) begin
        case (cmd_q)
          CMD_ALLOC: begin
            if (hit_q) begin
              if (pop_ok) begin
                cnt_q[cls_lo] <= cnt_q[cls_lo] - 1'b1;
                valid_q[slot_q] <= 1'b1;
              end else begin
                // pointer moves even when the block does not fit
                bump_q <= nxt;
                if (nxt < {1'b0, pool_size_i}) valid_q[slot_q] <= 1'b1;
              end
            end
          end
          CMD_RELEASE: begin
            if (hit_q && refs_dec == '0) begin
              valid_q[slot_q] <= 1'b0;
              if (fcls != CLS_NONE && cnt_q[fcls_lo] < CNT_W'(STACK_DEPTH)) begin
                cnt_q[fcls_lo] <= cnt_q[fcls_lo] + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/size_class_buffer_allocator_top.sv @@
// top level of the size class buffer allocator
//
//   channel   dir  handshake          payload
//   in_i      in   valid/ready        cmd, req_size, handle_in
//   out_o     out  valid/ready        status, handle_out, block_offset, block_bytes, freed
//   apb       in   psel/penable       pool_size at byte address 0
//
// a request is captured at its accepting edge; handle match, slot select with table
// and stack memory reads, and execute follow as registered steps in that order, and
// the result register then drives a valid result in the output state
// the result is held until taken; no new request is accepted meanwhile, so the block
// does not take a new request before the result of the last one has been taken
// reset clears pointer, handle counter, slot valid bits and stack counts at once
`default_nettype none
module size_class_buffer_allocator_top
  import scba_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  scba_req_if.sink         in_i,
  scba_rsp_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] pool_size_q;
  ctrl_t       ctrl;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_POOL_SIZE) ? pool_size_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= POOL_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_POOL_SIZE) begin
      pool_size_q <= pwdata;
    end
  end

  scba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  scba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .pool_size_i    (pool_size_q),
    .cmd_i          (in_i.cmd),
    .req_size_i     (in_i.req_size),
    .handle_in_i    (in_i.handle_in),
    .status_o       (out_o.status),
    .handle_out_o   (out_o.handle_out),
    .block_offset_o (out_o.block_offset),
    .block_bytes_o  (out_o.block_bytes),
    .freed_o        (out_o.freed)
  );

endmodule
`default_nettype wire
